// ===== rtl/abbt_pkg.sv =====
// Package for the affine bounding box transform: fixed-point constants and
// configuration register indexes. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package abbt_pkg;

  // Number of fraction bits in every coordinate, coefficient and offset.
  localparam int unsigned FracBits = 16;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 3;

  // Configuration register map.
  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_XX  = 3'd0,
    REG_COEF_XY  = 3'd1,
    REG_COEF_YX  = 3'd2,
    REG_COEF_YY  = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5
  } cfg_reg_e;

endpackage

// ===== rtl/abbt_if.sv =====
// Handshake channels of the affine bounding box transform: rectangle input,
// box output and configuration write. Depends on abbt_pkg.
`timescale 1ns / 1ps

// Rectangle channel: two opposite corners in signed fixed point.
interface abbt_rect_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rect_min_x;
  logic signed [COORD_WIDTH-1:0] rect_min_y;
  logic signed [COORD_WIDTH-1:0] rect_max_x;
  logic signed [COORD_WIDTH-1:0] rect_max_y;

  modport source (output valid, rect_min_x, rect_min_y, rect_max_x, rect_max_y,
                  input ready);
  modport sink   (input valid, rect_min_x, rect_min_y, rect_max_x, rect_max_y,
                  output ready);
endinterface

// Box channel: axis-aligned bounds of the mapped corners plus a clamp flag.
interface abbt_box_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic                          saturated;

  modport source (output valid, box_min_x, box_min_y, box_max_x, box_max_y,
                  saturated, input ready);
  modport sink   (input valid, box_min_x, box_min_y, box_max_x, box_max_y,
                  saturated, output ready);
endinterface

// Configuration write channel: register index and data.
interface abbt_cfg_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  import abbt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CfgIdxW-1:0]     index;
  logic [COORD_WIDTH-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/affine_bounding_box_transform.sv =====
// Affine bounding box transform: maps the four corners of a rectangle through
// a 2D affine transform and outputs their bounding box. Depends on abbt_pkg, abbt_if.
`timescale 1ns / 1ps

// The block returns one box beat for each rectangle beat, in order, and takes
// one rectangle beat per clock cycle while the output side does not
// stall. The five register stages are: split partial products of the eight
// coefficient-by-coordinate multiplies, product assembly, corner sums with the
// offsets, floor and clamp to the coordinate range, and the min/max selection
// into the output register. Each stage holds its beat while the next one is
// full, so back-pressure propagates without loss. Coefficients and offsets are
// written over the configuration channel, which is always ready; writes must be
// made while no rectangle is in flight. Writes to an index past offset_y are
// dropped.
module affine_bounding_box_transform #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  abbt_cfg_if.sink   cfg_i,
  abbt_rect_if.sink  rect_i,
  abbt_box_if.source box_o
);
  import abbt_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned L    = W / 2;          // low operand slice, unsigned
  localparam int unsigned H    = W - L;          // high operand slice, signed
  localparam int unsigned PHW  = W + H;          // high partial product width
  localparam int unsigned PLW  = W + L + 1;      // low partial product width
  localparam int unsigned PW   = 2 * W;          // full product width
  localparam int unsigned SW   = 2 * W + 2;      // corner sum width
  localparam int unsigned FW   = SW - FracBits;  // floored sum width
  localparam int unsigned NSt  = 5;              // pipeline depth
  localparam int unsigned NProd = 8;

  localparam logic signed [W-1:0] CoefOne  = {{(W-1){1'b0}}, 1'b1} << FracBits;
  localparam logic signed [W-1:0] CoordMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CoordMin = {1'b1, {(W-1){1'b0}}};

  // Configuration registers.
  logic signed [W-1:0] coef_xx_q, coef_xy_q, coef_yx_q, coef_yy_q;
  logic signed [W-1:0] offset_x_q, offset_y_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q  <= CoefOne;
      coef_xy_q  <= '0;
      coef_yx_q  <= '0;
      coef_yy_q  <= CoefOne;
      offset_x_q <= '0;
      offset_y_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_COEF_XX:  coef_xx_q  <= cfg_i.data;
        REG_COEF_XY:  coef_xy_q  <= cfg_i.data;
        REG_COEF_YX:  coef_yx_q  <= cfg_i.data;
        REG_COEF_YY:  coef_yy_q  <= cfg_i.data;
        REG_OFFSET_X: offset_x_q <= cfg_i.data;
        REG_OFFSET_Y: offset_y_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor moves on.
  logic [NSt-1:0] vld_q;
  logic [NSt-1:0] en;

  always_comb begin
    en[NSt-1] = !vld_q[NSt-1] || box_o.ready;
    for (int k = NSt - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign rect_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= rect_i.valid;
      end
      for (int k = 1; k < NSt; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 1: partial products. Product m uses coefficient m/2 (xx, yx, xy, yy)
  // against the x corners for even pairs and the y corners for odd pairs.
  logic signed [W-1:0]   coef_sel [4];
  logic signed [W-1:0]   x_in [2];
  logic signed [W-1:0]   y_in [2];
  logic signed [W-1:0]   op;
  logic signed [H-1:0]   op_hi;
  logic signed [L:0]     op_lo;
  logic signed [PHW-1:0] pp_hi_d [NProd];
  logic signed [PLW-1:0] pp_lo_d [NProd];
  logic signed [PHW-1:0] pp_hi_q [NProd];
  logic signed [PLW-1:0] pp_lo_q [NProd];

  always_comb begin
    coef_sel[0] = coef_xx_q;
    coef_sel[1] = coef_yx_q;
    coef_sel[2] = coef_xy_q;
    coef_sel[3] = coef_yy_q;
    x_in[0]     = rect_i.rect_min_x;
    x_in[1]     = rect_i.rect_max_x;
    y_in[0]     = rect_i.rect_min_y;
    y_in[1]     = rect_i.rect_max_y;
    op          = '0;
    op_hi       = '0;
    op_lo       = '0;
    for (int m = 0; m < NProd; m++) begin
      op         = ((m / 2) % 2 == 0) ? x_in[m % 2] : y_in[m % 2];
      op_hi      = op[W-1:L];
      op_lo      = {1'b0, op[L-1:0]};
      pp_hi_d[m] = PHW'(coef_sel[m / 2]) * PHW'(op_hi);
      pp_lo_d[m] = PLW'(coef_sel[m / 2]) * PLW'(op_lo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pp_hi_q <= pp_hi_d;
      pp_lo_q <= pp_lo_d;
    end
  end

  // Stage 2: assemble the full products from the two slices.
  logic signed [PW-1:0] prod_d [NProd];
  logic signed [PW-1:0] prod_q [NProd];

  always_comb begin
    for (int m = 0; m < NProd; m++) begin
      prod_d[m] = (PW'(pp_hi_q[m]) <<< L) + PW'(pp_lo_q[m]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      prod_q <= prod_d;
    end
  end

  // Stage 3: corner sums. Corners in order are (min x, min y), (min x, max y),
  // (max x, max y) and (max x, min y).
  localparam logic [3:0] CornerXi = 4'b1100;
  localparam logic [3:0] CornerYi = 4'b0110;

  logic signed [SW-1:0] off_x_al, off_y_al;
  logic signed [SW-1:0] sum_x_d [4];
  logic signed [SW-1:0] sum_y_d [4];
  logic signed [SW-1:0] sum_x_q [4];
  logic signed [SW-1:0] sum_y_q [4];

  always_comb begin
    off_x_al = {{(SW-W-FracBits){offset_x_q[W-1]}}, offset_x_q, {FracBits{1'b0}}};
    off_y_al = {{(SW-W-FracBits){offset_y_q[W-1]}}, offset_y_q, {FracBits{1'b0}}};
    for (int i = 0; i < 4; i++) begin
      sum_x_d[i] = SW'(prod_q[0 + 32'(CornerXi[i])]) + SW'(prod_q[2 + 32'(CornerYi[i])])
                   + off_x_al;
      sum_y_d[i] = SW'(prod_q[4 + 32'(CornerXi[i])]) + SW'(prod_q[6 + 32'(CornerYi[i])])
                   + off_y_al;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
    end
  end

  // Stage 4: floor to the coordinate scale and clamp to the signed range.
  logic signed [W-1:0] pt_x_d [4];
  logic signed [W-1:0] pt_y_d [4];
  logic signed [W-1:0] pt_x_q [4];
  logic signed [W-1:0] pt_y_q [4];
  logic [7:0]          clip_d;
  logic                sat_q;
  logic [FW-1:0]       fl_x, fl_y;

  always_comb begin
    fl_x = '0;
    fl_y = '0;
    for (int i = 0; i < 4; i++) begin
      fl_x = sum_x_q[i][SW-1:FracBits];
      fl_y = sum_y_q[i][SW-1:FracBits];
      // In range when every bit above the result's sign matches it.
      if ((&fl_x[FW-1:W-1]) || !(|fl_x[FW-1:W-1])) begin
        pt_x_d[i]   = fl_x[W-1:0];
        clip_d[2*i] = 1'b0;
      end else begin
        pt_x_d[i]   = fl_x[FW-1] ? CoordMin : CoordMax;
        clip_d[2*i] = 1'b1;
      end
      if ((&fl_y[FW-1:W-1]) || !(|fl_y[FW-1:W-1])) begin
        pt_y_d[i]     = fl_y[W-1:0];
        clip_d[2*i+1] = 1'b0;
      end else begin
        pt_y_d[i]     = fl_y[FW-1] ? CoordMin : CoordMax;
        clip_d[2*i+1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      pt_x_q <= pt_x_d;
      pt_y_q <= pt_y_d;
      sat_q  <= |clip_d;
    end
  end

  // Stage 5: min and max over the four corners, as a two-level compare tree.
  logic signed [W-1:0] mnx01, mnx23, mxx01, mxx23;
  logic signed [W-1:0] mny01, mny23, mxy01, mxy23;
  logic signed [W-1:0] box_min_x_q, box_min_y_q, box_max_x_q, box_max_y_q;
  logic                box_sat_q;

  always_comb begin
    mnx01 = (pt_x_q[1] < pt_x_q[0]) ? pt_x_q[1] : pt_x_q[0];
    mnx23 = (pt_x_q[3] < pt_x_q[2]) ? pt_x_q[3] : pt_x_q[2];
    mxx01 = (pt_x_q[1] > pt_x_q[0]) ? pt_x_q[1] : pt_x_q[0];
    mxx23 = (pt_x_q[3] > pt_x_q[2]) ? pt_x_q[3] : pt_x_q[2];
    mny01 = (pt_y_q[1] < pt_y_q[0]) ? pt_y_q[1] : pt_y_q[0];
    mny23 = (pt_y_q[3] < pt_y_q[2]) ? pt_y_q[3] : pt_y_q[2];
    mxy01 = (pt_y_q[1] > pt_y_q[0]) ? pt_y_q[1] : pt_y_q[0];
    mxy23 = (pt_y_q[3] > pt_y_q[2]) ? pt_y_q[3] : pt_y_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      box_min_x_q <= (mnx23 < mnx01) ? mnx23 : mnx01;
      box_max_x_q <= (mxx23 > mxx01) ? mxx23 : mxx01;
      box_min_y_q <= (mny23 < mny01) ? mny23 : mny01;
      box_max_y_q <= (mxy23 > mxy01) ? mxy23 : mxy01;
      box_sat_q   <= sat_q;
    end
  end

  // Output beat.
  assign box_o.valid     = vld_q[NSt-1];
  assign box_o.box_min_x = box_min_x_q;
  assign box_o.box_min_y = box_min_y_q;
  assign box_o.box_max_x = box_max_x_q;
  assign box_o.box_max_y = box_max_y_q;
  assign box_o.saturated = box_sat_q;

endmodule
